// ----- hdl/rmch_pkg.sv -----
package rmch_pkg;

    localparam int COORD_W     = 32;
    localparam int FRAC_BITS   = 16;
    localparam int WIDE_W      = 3 * COORD_W + 8;
    localparam int DIG_W       = 8;
    localparam int NDIG        = WIDE_W / DIG_W;
    localparam int PROD_W      = 2 * WIDE_W;
    localparam int DIV_W       = WIDE_W + 32;
    localparam int DIST_W      = 31;
    localparam int IDX_W       = 10;
    localparam int COUNT_W     = 11;
    localparam int EPS_W       = 32;
    localparam int TMIN_W      = 31;
    localparam int MAX_TRI_DEF = 1024;
    localparam int PC_W        = 5;

    typedef logic [PC_W-1:0] t_pc;

    // last micro-op of each group in the per-triangle program
    localparam t_pc PC_DET_END = 5'd8;
    localparam t_pc PC_TN_END  = 5'd23;
    localparam t_pc PC_TMIN    = 5'd24;
    localparam t_pc PC_CMP_END = 5'd26;

    typedef struct packed {
        logic                      mode;
        logic [IDX_W-1:0]          tri_index;
        logic signed [COORD_W-1:0] a_x;
        logic signed [COORD_W-1:0] a_y;
        logic signed [COORD_W-1:0] a_z;
        logic signed [COORD_W-1:0] b_x;
        logic signed [COORD_W-1:0] b_y;
        logic signed [COORD_W-1:0] b_z;
        logic signed [COORD_W-1:0] c_x;
        logic signed [COORD_W-1:0] c_y;
        logic signed [COORD_W-1:0] c_z;
    } t_in_item;

    typedef struct packed {
        logic              hit;
        logic [IDX_W-1:0]  hit_tri;
        logic [DIST_W-1:0] hit_distance;
    } t_out_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] v0_x;
        logic signed [COORD_W-1:0] v0_y;
        logic signed [COORD_W-1:0] v0_z;
        logic signed [COORD_W-1:0] e1_x;
        logic signed [COORD_W-1:0] e1_y;
        logic signed [COORD_W-1:0] e1_z;
        logic signed [COORD_W-1:0] e2_x;
        logic signed [COORD_W-1:0] e2_y;
        logic signed [COORD_W-1:0] e2_z;
    } t_tri;

    typedef struct packed {
        logic [COUNT_W-1:0] tri_count;
        logic [EPS_W-1:0]   det_eps;
        logic [TMIN_W-1:0]  t_min;
    } t_cfg;

    typedef enum logic [1:0] {
        CFG_TRI_COUNT = 2'd0,
        CFG_DET_EPS   = 2'd1,
        CFG_T_MIN     = 2'd2
    } t_cfg_idx;

    typedef enum logic [4:0] {
        SRC_DX, SRC_DY, SRC_DZ,
        SRC_E1X, SRC_E1Y, SRC_E1Z,
        SRC_E2X, SRC_E2Y, SRC_E2Z,
        SRC_SX, SRC_SY, SRC_SZ,
        SRC_HX, SRC_HY, SRC_HZ,
        SRC_QX, SRC_QY, SRC_QZ,
        SRC_DET, SRC_TN, SRC_TMIN, SRC_BDET, SRC_BNUM
    } t_src;

    typedef enum logic [3:0] {
        DST_NONE, DST_HX, DST_HY, DST_HZ, DST_DET,
        DST_QX, DST_QY, DST_QZ, DST_UN, DST_VN, DST_TN
    } t_dst;

    typedef struct packed {
        t_src a;
        t_src b;
        logic sub;
        logic first;
        logic last;
        t_dst dst;
    } t_mac_op;

    typedef enum logic [3:0] {
        S_IDLE, S_FETCH, S_LOAD, S_MAC_GO, S_MAC_WAIT,
        S_DET_ABS, S_DET_CHK, S_FLIP, S_UV_CHK, S_T_CHK,
        S_BEST_CHK, S_BEST_UPD, S_NEXT, S_DIV_GO, S_DIV_WAIT, S_OUT
    } t_state;

    typedef struct packed {
        t_mac_op op;
        logic    store_wr;
        logic    ray_load;
        logic    rd_issue;
        logic    tri_load;
        logic    mac_start;
        logic    mac_acc;
        logic    det_fix;
        logic    uvt_flip;
        logic    best_upd;
        logic    idx_inc;
        logic    div_start;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic more;
        logic det_ok;
        logic uv_ok;
        logic t_ok;
        logic closer;
        logic found;
        logic out_busy;
    } t_stat;

    function automatic t_mac_op mk_op(input t_src a, input t_src b, input logic sub,
                                      input logic first, input logic last, input t_dst dst);
        t_mac_op op;
        op.a     = a;
        op.b     = b;
        op.sub   = sub;
        op.first = first;
        op.last  = last;
        op.dst   = dst;
        return op;
    endfunction

    // per-triangle multiply-accumulate program: h, det, q, u, v, t, t_min test, ordering
    function automatic t_mac_op mac_prog(input t_pc pc);
        t_mac_op op;
        case (pc)
            5'd0:    op = mk_op(SRC_DY,   SRC_E2Z,  1'b0, 1'b1, 1'b0, DST_NONE);
            5'd1:    op = mk_op(SRC_DZ,   SRC_E2Y,  1'b1, 1'b0, 1'b1, DST_HX);
            5'd2:    op = mk_op(SRC_DZ,   SRC_E2X,  1'b0, 1'b1, 1'b0, DST_NONE);
            5'd3:    op = mk_op(SRC_DX,   SRC_E2Z,  1'b1, 1'b0, 1'b1, DST_HY);
            5'd4:    op = mk_op(SRC_DX,   SRC_E2Y,  1'b0, 1'b1, 1'b0, DST_NONE);
            5'd5:    op = mk_op(SRC_DY,   SRC_E2X,  1'b1, 1'b0, 1'b1, DST_HZ);
            5'd6:    op = mk_op(SRC_E1X,  SRC_HX,   1'b0, 1'b1, 1'b0, DST_NONE);
            5'd7:    op = mk_op(SRC_E1Y,  SRC_HY,   1'b0, 1'b0, 1'b0, DST_NONE);
            5'd8:    op = mk_op(SRC_E1Z,  SRC_HZ,   1'b0, 1'b0, 1'b1, DST_DET);
            5'd9:    op = mk_op(SRC_SY,   SRC_E1Z,  1'b0, 1'b1, 1'b0, DST_NONE);
            5'd10:   op = mk_op(SRC_SZ,   SRC_E1Y,  1'b1, 1'b0, 1'b1, DST_QX);
            5'd11:   op = mk_op(SRC_SZ,   SRC_E1X,  1'b0, 1'b1, 1'b0, DST_NONE);
            5'd12:   op = mk_op(SRC_SX,   SRC_E1Z,  1'b1, 1'b0, 1'b1, DST_QY);
            5'd13:   op = mk_op(SRC_SX,   SRC_E1Y,  1'b0, 1'b1, 1'b0, DST_NONE);
            5'd14:   op = mk_op(SRC_SY,   SRC_E1X,  1'b1, 1'b0, 1'b1, DST_QZ);
            5'd15:   op = mk_op(SRC_SX,   SRC_HX,   1'b0, 1'b1, 1'b0, DST_NONE);
            5'd16:   op = mk_op(SRC_SY,   SRC_HY,   1'b0, 1'b0, 1'b0, DST_NONE);
            5'd17:   op = mk_op(SRC_SZ,   SRC_HZ,   1'b0, 1'b0, 1'b1, DST_UN);
            5'd18:   op = mk_op(SRC_DX,   SRC_QX,   1'b0, 1'b1, 1'b0, DST_NONE);
            5'd19:   op = mk_op(SRC_DY,   SRC_QY,   1'b0, 1'b0, 1'b0, DST_NONE);
            5'd20:   op = mk_op(SRC_DZ,   SRC_QZ,   1'b0, 1'b0, 1'b1, DST_VN);
            5'd21:   op = mk_op(SRC_E2X,  SRC_QX,   1'b0, 1'b1, 1'b0, DST_NONE);
            5'd22:   op = mk_op(SRC_E2Y,  SRC_QY,   1'b0, 1'b0, 1'b0, DST_NONE);
            5'd23:   op = mk_op(SRC_E2Z,  SRC_QZ,   1'b0, 1'b0, 1'b1, DST_TN);
            5'd24:   op = mk_op(SRC_TMIN, SRC_DET,  1'b0, 1'b1, 1'b1, DST_NONE);
            5'd25:   op = mk_op(SRC_TN,   SRC_BDET, 1'b0, 1'b1, 1'b0, DST_NONE);
            5'd26:   op = mk_op(SRC_BNUM, SRC_DET,  1'b1, 1'b0, 1'b1, DST_NONE);
            default: op = mk_op(SRC_DX,   SRC_DX,   1'b0, 1'b1, 1'b1, DST_NONE);
        endcase
        return op;
    endfunction

endpackage

// ----- hdl/rmch_mul.sv -----
module rmch_mul (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [rmch_pkg::WIDE_W-1:0] i_a,
    input  logic signed [rmch_pkg::WIDE_W-1:0] i_b,
    output logic                               o_done,
    output logic signed [rmch_pkg::PROD_W-1:0] o_prod
);
    import rmch_pkg::*;

    localparam int CNT_W = $clog2(NDIG + 1);

    logic [WIDE_W-1:0]       r_ma, r_mb;
    logic [PROD_W-1:0]       r_acc;
    logic                    r_sign, r_busy, r_fin, r_done;
    logic [CNT_W-1:0]        r_cnt;
    logic signed [PROD_W-1:0] r_prod;
    logic [WIDE_W-1:0]       ma, mb;
    logic [WIDE_W+DIG_W-1:0] pp;

    assign ma = i_a[WIDE_W-1] ? WIDE_W'(-i_a) : WIDE_W'(i_a);
    assign mb = i_b[WIDE_W-1] ? WIDE_W'(-i_b) : WIDE_W'(i_b);
    // one multiplier digit per cycle, most significant first
    assign pp = {{DIG_W{1'b0}}, r_ma} * {{WIDE_W{1'b0}}, r_mb[WIDE_W-1 -: DIG_W]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NDIG);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ma   <= ma;
            r_mb   <= mb;
            r_sign <= i_a[WIDE_W-1] ^ i_b[WIDE_W-1];
            r_acc  <= '0;
        end else if (r_busy) begin
            r_acc <= (r_acc << DIG_W) + PROD_W'(pp);
            r_mb  <= r_mb << DIG_W;
        end else if (r_fin) begin
            r_prod <= r_sign ? $signed(-r_acc) : $signed(r_acc);
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule

// ----- hdl/rmch_div.sv -----
module rmch_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rmch_pkg::DIV_W-1:0]  i_num,
    input  logic [rmch_pkg::WIDE_W-1:0] i_den,
    output logic                        o_done,
    output logic [rmch_pkg::DIST_W-1:0] o_quot
);
    import rmch_pkg::*;

    localparam int CNT_W = $clog2(DIST_W + 1);

    logic [DIV_W-1:0]  r_num, r_den;
    logic [DIST_W-1:0] r_q;
    logic              r_sat, r_busy, r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic              fits;

    assign fits = r_den <= r_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIST_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // restoring division, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= DIV_W'(i_den) << (DIST_W - 1);
            r_sat <= i_num >= (DIV_W'(i_den) << DIST_W);
            r_q   <= '0;
        end else if (r_busy) begin
            if (fits) begin
                r_num <= r_num - r_den;
            end
            r_q   <= {r_q[DIST_W-2:0], fits};
            r_den <= r_den >> 1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_sat ? {DIST_W{1'b1}} : r_q;

endmodule

// ----- hdl/rmch_datapath.sv -----
module rmch_datapath #(
    parameter int MAX_TRIANGLES = rmch_pkg::MAX_TRI_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rmch_pkg::t_cmd      i_cmd,
    output rmch_pkg::t_stat     o_stat,
    input  rmch_pkg::t_cfg      i_cfg,
    input  rmch_pkg::t_in_item  i_in_item,
    output rmch_pkg::t_out_item o_out_item,
    output logic                o_out_valid,
    input  logic                i_out_ready
);
    import rmch_pkg::*;

    localparam int AW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
    localparam int CW = $clog2(MAX_TRIANGLES + 1);

    t_tri mem [MAX_TRIANGLES];
    t_tri r_rd;

    logic signed [COORD_W-1:0] r_ox, r_oy, r_oz, r_dx, r_dy, r_dz;
    logic signed [COORD_W:0]   r_sx, r_sy, r_sz;
    logic signed [WIDE_W-1:0]  r_hx, r_hy, r_hz, r_qx, r_qy, r_qz;
    logic signed [WIDE_W-1:0]  r_det, r_un, r_vn, r_tn, r_bnum, r_bdet;
    logic signed [PROD_W-1:0]  r_sum, n_sum;
    logic                      r_flip, r_found, r_out_valid;
    logic [AW-1:0]             r_bidx;
    logic [CW-1:0]             r_idx, r_n;
    t_out_item                 r_out;

    logic signed [WIDE_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0]  prod, tn_sh;
    logic                      mul_done, div_done;
    logic [DIST_W-1:0]         quot;
    logic [WIDE_W-1:0]         eps_w;
    logic [WIDE_W:0]           uv_sum;

    function automatic logic signed [WIDE_W-1:0] pick(input t_src s);
        case (s)
            SRC_DX:   return WIDE_W'(r_dx);
            SRC_DY:   return WIDE_W'(r_dy);
            SRC_DZ:   return WIDE_W'(r_dz);
            SRC_E1X:  return WIDE_W'(r_rd.e1_x);
            SRC_E1Y:  return WIDE_W'(r_rd.e1_y);
            SRC_E1Z:  return WIDE_W'(r_rd.e1_z);
            SRC_E2X:  return WIDE_W'(r_rd.e2_x);
            SRC_E2Y:  return WIDE_W'(r_rd.e2_y);
            SRC_E2Z:  return WIDE_W'(r_rd.e2_z);
            SRC_SX:   return WIDE_W'(r_sx);
            SRC_SY:   return WIDE_W'(r_sy);
            SRC_SZ:   return WIDE_W'(r_sz);
            SRC_HX:   return r_hx;
            SRC_HY:   return r_hy;
            SRC_HZ:   return r_hz;
            SRC_QX:   return r_qx;
            SRC_QY:   return r_qy;
            SRC_QZ:   return r_qz;
            SRC_DET:  return r_det;
            SRC_TN:   return r_tn;
            SRC_TMIN: return $signed(WIDE_W'(i_cfg.t_min));
            SRC_BDET: return r_bdet;
            SRC_BNUM: return r_bnum;
            default:  return '0;
        endcase
    endfunction

    assign mul_a = pick(i_cmd.op.a);
    assign mul_b = pick(i_cmd.op.b);

    rmch_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mac_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (prod)
    );

    rmch_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (DIV_W'($unsigned(r_bnum)) << FRAC_BITS),
        .i_den   ($unsigned(r_bdet)),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    always_comb begin
        if (i_cmd.op.first) begin
            n_sum = i_cmd.op.sub ? -prod : prod;
        end else begin
            n_sum = i_cmd.op.sub ? r_sum - prod : r_sum + prod;
        end
    end

    assign eps_w  = WIDE_W'(i_cfg.det_eps) << FRAC_BITS;
    assign uv_sum = (WIDE_W+1)'($unsigned(r_un)) + (WIDE_W+1)'($unsigned(r_vn));
    assign tn_sh  = PROD_W'(r_tn) <<< FRAC_BITS;

    always_comb begin
        o_stat.mul_done = mul_done;
        o_stat.div_done = div_done;
        o_stat.more     = r_idx < r_n;
        o_stat.det_ok   = (r_det != '0) && ($unsigned(r_det) >= eps_w);
        o_stat.uv_ok    = !r_un[WIDE_W-1] && !r_vn[WIDE_W-1]
                          && (uv_sum <= (WIDE_W+1)'($unsigned(r_det)));
        o_stat.t_ok     = tn_sh > r_sum;
        o_stat.closer   = r_sum[PROD_W-1];
        o_stat.found    = r_found;
        o_stat.out_busy = r_out_valid;
    end

    // triangle store: written by store items, read one slot per fetch
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_wr && (32'(i_in_item.tri_index) < 32'(MAX_TRIANGLES))) begin
            mem[AW'(i_in_item.tri_index)] <= '{
                i_in_item.a_x, i_in_item.a_y, i_in_item.a_z,
                i_in_item.b_x, i_in_item.b_y, i_in_item.b_z,
                i_in_item.c_x, i_in_item.c_y, i_in_item.c_z};
        end
        if (i_cmd.rd_issue) begin
            r_rd <= mem[r_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found     <= 1'b0;
            r_idx       <= '0;
            r_n         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.ray_load) begin
                r_found <= 1'b0;
                r_idx   <= '0;
                r_n     <= (32'(i_cfg.tri_count) > 32'(MAX_TRIANGLES))
                           ? CW'(MAX_TRIANGLES) : CW'(i_cfg.tri_count);
            end
            if (i_cmd.best_upd) begin
                r_found <= 1'b1;
            end
            if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ray_load) begin
            r_ox <= i_in_item.a_x;
            r_oy <= i_in_item.a_y;
            r_oz <= i_in_item.a_z;
            r_dx <= i_in_item.b_x;
            r_dy <= i_in_item.b_y;
            r_dz <= i_in_item.b_z;
        end
        if (i_cmd.tri_load) begin
            r_sx <= (COORD_W+1)'(r_ox) - (COORD_W+1)'(r_rd.v0_x);
            r_sy <= (COORD_W+1)'(r_oy) - (COORD_W+1)'(r_rd.v0_y);
            r_sz <= (COORD_W+1)'(r_oz) - (COORD_W+1)'(r_rd.v0_z);
        end
        if (i_cmd.mac_acc) begin
            r_sum <= n_sum;
            if (i_cmd.op.last) begin
                case (i_cmd.op.dst)
                    DST_HX:  r_hx  <= n_sum[WIDE_W-1:0];
                    DST_HY:  r_hy  <= n_sum[WIDE_W-1:0];
                    DST_HZ:  r_hz  <= n_sum[WIDE_W-1:0];
                    DST_DET: r_det <= n_sum[WIDE_W-1:0];
                    DST_QX:  r_qx  <= n_sum[WIDE_W-1:0];
                    DST_QY:  r_qy  <= n_sum[WIDE_W-1:0];
                    DST_QZ:  r_qz  <= n_sum[WIDE_W-1:0];
                    DST_UN:  r_un  <= n_sum[WIDE_W-1:0];
                    DST_VN:  r_vn  <= n_sum[WIDE_W-1:0];
                    DST_TN:  r_tn  <= n_sum[WIDE_W-1:0];
                    default: ;
                endcase
            end
        end
        if (i_cmd.det_fix) begin
            r_flip <= r_det[WIDE_W-1];
            if (r_det[WIDE_W-1]) begin
                r_det <= -r_det;
            end
        end
        if (i_cmd.uvt_flip && r_flip) begin
            r_un <= -r_un;
            r_vn <= -r_vn;
            r_tn <= -r_tn;
        end
        if (i_cmd.best_upd) begin
            r_bidx <= r_idx[AW-1:0];
            r_bnum <= r_tn;
            r_bdet <= r_det;
        end
        if (i_cmd.out_load) begin
            r_out.hit          <= r_found;
            r_out.hit_tri      <= r_found ? IDX_W'(r_bidx) : '0;
            r_out.hit_distance <= r_found ? quot : '0;
        end
    end

    assign o_out_item  = r_out;
    assign o_out_valid = r_out_valid;

endmodule

// ----- hdl/rmch_ctrl.sv -----
module rmch_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_mode,
    output logic            o_in_ready,
    output rmch_pkg::t_cmd  o_cmd,
    input  rmch_pkg::t_stat i_stat
);
    import rmch_pkg::*;

    t_state r_state, n_state;
    t_pc    r_pc, n_pc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
        end
    end

    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_in_mode) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                if (i_stat.more) begin
                    n_state = S_LOAD;
                end else if (i_stat.found) begin
                    n_state = S_DIV_GO;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_LOAD: begin
                n_pc    = '0;
                n_state = S_MAC_GO;
            end
            S_MAC_GO: n_state = S_MAC_WAIT;
            S_MAC_WAIT: begin
                if (i_stat.mul_done) begin
                    n_pc = r_pc + 1'b1;
                    case (r_pc)
                        PC_DET_END: n_state = S_DET_ABS;
                        PC_TN_END:  n_state = S_FLIP;
                        PC_TMIN:    n_state = S_T_CHK;
                        PC_CMP_END: n_state = S_BEST_CHK;
                        default:    n_state = S_MAC_GO;
                    endcase
                end
            end
            S_DET_ABS: n_state = S_DET_CHK;
            S_DET_CHK: n_state = i_stat.det_ok ? S_MAC_GO : S_NEXT;
            S_FLIP:    n_state = S_UV_CHK;
            S_UV_CHK:  n_state = i_stat.uv_ok ? S_MAC_GO : S_NEXT;
            S_T_CHK: begin
                if (!i_stat.t_ok) begin
                    n_state = S_NEXT;
                end else if (!i_stat.found) begin
                    n_state = S_BEST_UPD;
                end else begin
                    n_state = S_MAC_GO;
                end
            end
            S_BEST_CHK: n_state = i_stat.closer ? S_BEST_UPD : S_NEXT;
            S_BEST_UPD: n_state = S_NEXT;
            S_NEXT:     n_state = S_FETCH;
            S_DIV_GO:   n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_stat.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.op   = mac_prog(r_pc);
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.store_wr = i_in_valid && !i_in_mode;
                o_cmd.ray_load = i_in_valid && i_in_mode;
            end
            S_FETCH:    o_cmd.rd_issue  = i_stat.more;
            S_LOAD:     o_cmd.tri_load  = 1'b1;
            S_MAC_GO:   o_cmd.mac_start = 1'b1;
            S_MAC_WAIT: o_cmd.mac_acc   = i_stat.mul_done;
            S_DET_ABS:  o_cmd.det_fix   = 1'b1;
            S_FLIP:     o_cmd.uvt_flip  = 1'b1;
            S_BEST_UPD: o_cmd.best_upd  = 1'b1;
            S_NEXT:     o_cmd.idx_inc   = 1'b1;
            S_DIV_GO:   o_cmd.div_start = 1'b1;
            S_OUT:      o_cmd.out_load  = !i_stat.out_busy;
            default: ;
        endcase
    end

    a_mul_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.mul_done |-> r_state == S_MAC_WAIT)
        else $error("multiplier finished outside a wait");

    a_div_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.div_done |-> r_state == S_DIV_WAIT)
        else $error("divider finished outside a wait");

    a_cmp_needs_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_BEST_CHK |-> i_stat.found)
        else $error("ordering test without a stored best hit");

    a_out_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !i_stat.out_busy) |=> (r_state == S_IDLE && i_stat.out_busy))
        else $error("result load did not complete");

endmodule

// ----- hdl/ray_mesh_closest_hit_unit.sv -----
// A store item is written straight from idle. A query fetches each of its triangles in
// turn and runs the multiply program on it, then divides when some triangle is hit.
// The multiply program runs on the shared 8-bit-digit multiplier: up to 27 wide
// products for each triangle. One item is worked on at a time.
// Synchronous active-low reset clears control and configuration; the triangle
// store is not cleared.
module ray_mesh_closest_hit_unit #(
    parameter int MAX_TRIANGLES = rmch_pkg::MAX_TRI_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rmch_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rmch_pkg::t_out_item o_out_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import rmch_pkg::*;

    t_cfg     r_cfg;
    t_cfg_idx cfg_idx;
    t_cmd     cmd;
    t_stat    stat;

    // registers sit at word addresses; the low two address bits are ignored
    assign cfg_idx = t_cfg_idx'(paddr[3:2]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tri_count <= '0;
            r_cfg.det_eps   <= EPS_W'(1);
            r_cfg.t_min     <= TMIN_W'(1);
        end else if (psel && penable && pwrite) begin
            case (cfg_idx)
                CFG_TRI_COUNT: r_cfg.tri_count <= pwdata[COUNT_W-1:0];
                CFG_DET_EPS:   r_cfg.det_eps   <= pwdata[EPS_W-1:0];
                CFG_T_MIN:     r_cfg.t_min     <= pwdata[TMIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            CFG_TRI_COUNT: prdata = 32'(r_cfg.tri_count);
            CFG_DET_EPS:   prdata = 32'(r_cfg.det_eps);
            CFG_T_MIN:     prdata = 32'(r_cfg.t_min);
            default:       prdata = '0;
        endcase
    end

    // controller: sequences fetch, the multiply program, tests and division
    rmch_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_mode  (i_in_item.mode),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    // datapath: triangle store, wide registers, multiplier, divider, result register
    rmch_datapath #(
        .MAX_TRIANGLES (MAX_TRIANGLES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg       (r_cfg),
        .i_in_item   (i_in_item),
        .o_out_item  (o_out_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready)
    );

endmodule
